// ----- src/ps2mct_pkg.sv -----
// Package: shared widths, codes and types of the PS/2 mouse cursor tracker.
package ps2mct_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int CFG_W       = 13;
  localparam int BYTE_W      = 8;
  localparam int DELTA_W     = 9;
  localparam int BTN_W       = 3;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int SIZE_W      = (CFG_W > COORD_WIDTH + 1) ? CFG_W : COORD_WIDTH + 1;
  localparam int SUM_W       = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] COORD_LIMIT = SIZE_W'(1) << COORD_WIDTH;

  localparam logic [CFG_W-1:0] SCREEN_W_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] SCREEN_H_RESET = CFG_W'(480);

  // Header byte bit positions
  localparam int LEFT_POS  = 0;
  localparam int SYNC_POS  = 3;
  localparam int XSIGN_POS = 4;
  localparam int YSIGN_POS = 5;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  typedef enum logic {
    REG_SCREEN_W = 1'b0,
    REG_SCREEN_H = 1'b1
  } reg_idx_t;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    coord_t base;
    delta_t delta;
    logic   negate;
  } axis_req_t;

endpackage

// ----- src/ps2mct_if.sv -----
// Interfaces: input byte channel and result channel of the cursor tracker.
interface ps2mct_in_if import ps2mct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface ps2mct_out_if import ps2mct_pkg::*; ();
  logic             valid;
  logic             ready;
  coord_t           cursor_x;
  coord_t           cursor_y;
  logic [BTN_W-1:0] button_bits;
  delta_t           delta_x;
  delta_t           delta_y;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output delta_x, output delta_y, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                  input delta_x, input delta_y, output ready);
endinterface

// ----- src/ps2_mouse_cursor_tracker_unit.sv -----
// Top level: PS/2 mouse packet decoder with clamped cursor tracking and APB config.
// Path: an accepted byte lands in the input register; the byte that completes a packet
//   then has its result registered in the result register, which offers it on out_ch.
// Throughput: one byte per cycle, but a byte completing a packet waits while the result
//   register is full and not being taken; a waiting result does not block stray bytes.
// Reset (rst_n low, synchronous): screen 640x480, packet phase at header, cursor
//   not yet centered, both pipeline stages empty.
module ps2_mouse_cursor_tracker_unit import ps2mct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ps2mct_in_if.sink         in_ch,
  ps2mct_out_if.source      out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Register index sits at paddr[2] (byte address 4*i).
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] screen_w_r;
  logic [CFG_W-1:0] screen_h_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RESET;
      screen_h_r <= SCREEN_H_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCREEN_W: screen_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_SCREEN_H: screen_h_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCREEN_W: cfg_prdata = DATA_W'(screen_w_r);
      REG_SCREEN_H: cfg_prdata = DATA_W'(screen_h_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: one byte per transaction.
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_aux_r;
  logic              s1_advance;
  logic              in_fire;

  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.data_byte;
      s1_aux_r  <= in_ch.from_aux;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet assembly and cursor update.
  // ---------------------------------------------------------------------------
  phase_t           phase_r, phase_nxt;
  logic [BYTE_W-1:0] header_r, header_nxt;
  logic [BYTE_W-1:0] xbyte_r, xbyte_nxt;
  coord_t           pos_x_r, pos_y_r;
  logic             centered_r;
  logic             out_valid_r;
  logic             out_free;
  logic             is_last;
  logic             pkt_done;
  coord_t           base_x, base_y;
  coord_t           new_x, new_y;
  delta_t           dx, dy;
  axis_req_t        req_x, req_y;
  logic [CFG_W-1:0] half_w, half_h;

  // The result register has room if empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = s1_valid_r && s1_aux_r && (phase_r == PH_Y);
  // Hold the byte only when it completes a packet and the result slot is busy
  assign s1_advance = s1_valid_r && (!is_last || out_free);
  assign pkt_done   = is_last && out_free;

  // Sign comes from the header; the data byte holds the low eight bits
  assign dx = {header_r[XSIGN_POS], xbyte_r};
  assign dy = {header_r[YSIGN_POS], s1_byte_r};

  // Center on the first packet using the screen size in force right now
  assign half_w = {1'b0, screen_w_r[CFG_W-1:1]};
  assign half_h = {1'b0, screen_h_r[CFG_W-1:1]};
  assign base_x = centered_r ? pos_x_r : COORD_WIDTH'(half_w);
  assign base_y = centered_r ? pos_y_r : COORD_WIDTH'(half_h);

  assign req_x = '{base: base_x, delta: dx, negate: 1'b0};
  assign req_y = '{base: base_y, delta: dy, negate: 1'b1};

  ps2mct_axis u_axis_x (.req(req_x), .screen(screen_w_r), .coord(new_x));
  ps2mct_axis u_axis_y (.req(req_y), .screen(screen_h_r), .coord(new_y));

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xbyte_nxt  = xbyte_r;
    if (s1_advance && s1_aux_r) begin
      case (phase_r)
        PH_X: begin
          xbyte_nxt = s1_byte_r;
          phase_nxt = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_HEAD;
        end
        default: begin
          // Drop a stray byte without the sync bit; otherwise start a packet
          if (s1_byte_r[SYNC_POS]) begin
            header_nxt = s1_byte_r;
            phase_nxt  = PH_X;
          end else begin
            phase_nxt = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      centered_r <= 1'b0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (pkt_done) begin
        centered_r <= 1'b1;
        pos_x_r    <= new_x;
        pos_y_r    <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    header_r <= header_nxt;
    xbyte_r  <= xbyte_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  coord_t           out_x_r, out_y_r;
  logic [BTN_W-1:0] out_btn_r;
  delta_t           out_dx_r, out_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pkt_done;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      out_x_r   <= new_x;
      out_y_r   <= new_y;
      out_btn_r <= header_r[LEFT_POS +: BTN_W];
      out_dx_r  <= dx;
      out_dy_r  <= dy;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_x    = out_x_r;
  assign out_ch.cursor_y    = out_y_r;
  assign out_ch.button_bits = out_btn_r;
  assign out_ch.delta_x     = out_dx_r;
  assign out_ch.delta_y     = out_dy_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pkt_result: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_done |=> out_valid_r)
    else $error("completed packet did not produce a result");

  a_pkt_centered: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_done |=> (centered_r && phase_r == PH_HEAD))
    else $error("packet completion did not center and rewind phase");

  a_non_aux_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_aux_r) |=> $stable(phase_r) && $stable(pos_x_r) && $stable(pos_y_r))
    else $error("byte from the keyboard port changed tracker state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(phase_r)))
    else $error("stalled input byte was lost or state advanced");

endmodule

// ----- src/ps2mct_axis.sv -----
// Axis update: apply a signed delta to one coordinate and clamp it to the screen.
module ps2mct_axis import ps2mct_pkg::*; (
  input  axis_req_t        req,
  input  logic [CFG_W-1:0] screen,
  output coord_t           coord
);

  logic [SIZE_W-1:0]        size_ext;
  logic [SIZE_W-1:0]        eff;
  logic signed [SUM_W-1:0]  base_s;
  logic signed [SUM_W-1:0]  delta_s;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  eff_s;

  always_comb begin
    size_ext = SIZE_W'(screen);
    // Zero-size screen acts as one pixel; oversize saturates to the coordinate range
    if (size_ext == '0) begin
      eff = SIZE_W'(1);
    end else if (size_ext > COORD_LIMIT) begin
      eff = COORD_LIMIT;
    end else begin
      eff = size_ext;
    end
    eff_s   = $signed(SUM_W'(eff));
    base_s  = $signed(SUM_W'(req.base));
    delta_s = SUM_W'(req.delta);
    sum     = req.negate ? (base_s - delta_s) : (base_s + delta_s);
    if (sum < 0) begin
      coord = '0;
    end else if (sum >= eff_s) begin
      coord = COORD_WIDTH'(eff - SIZE_W'(1));
    end else begin
      coord = sum[COORD_WIDTH-1:0];
    end
  end

endmodule
